// File: hw/rtl/nnis_pkg.sv
package nnis_pkg;

	// command codes on the input channel
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_FETCH = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_SRC_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SRC_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_DST_WIDTH  = 2'd2;
	localparam logic [1:0] CFG_DST_HEIGHT = 2'd3;

	localparam int SRC_DIM_BITS = 7;
	localparam int DST_DIM_BITS = 11;
	localparam int COORD_BITS   = 10;
	localparam int WORD_BITS    = 32;
	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 2;
	localparam logic [SRC_DIM_BITS-1:0] SRC_DIM_MAX = 7'd64;
	localparam logic [SRC_DIM_BITS-1:0] SRC_DIM_MIN = 7'd1;
	localparam logic [DST_DIM_BITS-1:0] DST_DIM_RESET = 11'd64;

	// source index range: up to 64 x 64 pixels
	localparam int INDEX_BITS = 12;
	localparam int AREA_BITS  = 13;
	// numerator of a coordinate division: 10 bit coordinate times 7 bit size
	localparam int NUM_BITS   = 16;
	// quotient is below the source size, so six bits
	localparam int QUOT_BITS  = 6;
	localparam int STEP_BITS  = 3;
	localparam logic [STEP_BITS-1:0] LAST_STEP = 3'(QUOT_BITS - 1);

	// reciprocal used to reduce an index modulo the store depth
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_BITS  = 25;
	localparam int DEPTH_BITS  = 17;

	localparam int QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_FETCH,
		KIND_ERROR
	} item_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_INDEX,
		BK_MOD_MUL,
		BK_MOD_SUB,
		BK_MOD_FIX,
		BK_READ,
		BK_DONE
	} back_state_t;

	// sizes as the datapath sees them, source sizes already clamped
	typedef struct packed {
		logic [SRC_DIM_BITS-1:0] src_w;
		logic [SRC_DIM_BITS-1:0] src_h;
		logic [DST_DIM_BITS-1:0] dst_w;
		logic [DST_DIM_BITS-1:0] dst_h;
	} cfg_t;

	typedef struct packed {
		item_kind_t            kind;
		logic [WORD_BITS-1:0]  pixel;
		logic [NUM_BITS-1:0]   num_x;
		logic [NUM_BITS-1:0]   num_y;
		logic [INDEX_BITS-1:0] ptr;
	} queue_entry_t;

	function automatic logic [SRC_DIM_BITS-1:0] clamp_src_dim(
		input logic [SRC_DIM_BITS-1:0] v
	);
		logic [SRC_DIM_BITS-1:0] r;
		r = v;
		if (v == '0) begin
			r = SRC_DIM_MIN;
		end else if (v > SRC_DIM_MAX) begin
			r = SRC_DIM_MAX;
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/nearest_neighbor_image_scaler.sv
// channel   | direction | handshake                   | word
// ----------+-----------+-----------------------------+---------------------------------
// input     | in        | in_valid / in_stall         | cmd, pixel_in, dst_x, dst_y
// result    | out       | out_valid / out_stall       | pixel_out, coord_error
// config    | in        | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// the front takes one word per cycle until the four entry queue fills
// back part: load walks MOD_MUL, MOD_SUB, MOD_FIX; fetch the bit-serial DIV, INDEX,
//   MOD_*, READ, DONE; out-of-range fetch DONE; the sequencer sets the sustained rate
// reset clears pointer, queue and sequencer and sets all four sizes to 64;
//   the pixel store is not cleared
// a stalled result holds in the output register while the front keeps filling
module nearest_neighbor_image_scaler #(
	parameter int MAX_PIXELS = 4096,
	parameter int PIXEL_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [nnis_pkg::WORD_BITS-1:0]      pixel_in,
	input  logic [nnis_pkg::COORD_BITS-1:0]     dst_x,
	input  logic [nnis_pkg::COORD_BITS-1:0]     dst_y,
	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [nnis_pkg::WORD_BITS-1:0]      pixel_out,
	output logic                                coord_error,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [nnis_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [nnis_pkg::CFG_BITS-1:0]       cfg_data
);

	import nnis_pkg::*;

	localparam int ENTRY_BITS = $bits(queue_entry_t);

	logic [SRC_DIM_BITS-1:0] src_width_q;
	logic [SRC_DIM_BITS-1:0] src_height_q;
	logic [DST_DIM_BITS-1:0] dst_width_q;
	logic [DST_DIM_BITS-1:0] dst_height_q;

	cfg_t                  cfg;
	queue_entry_t          push_entry;
	queue_entry_t          pop_entry;
	logic [ENTRY_BITS-1:0] pop_bits;
	logic                  push;
	logic                  pop;
	logic                  full;
	logic                  empty;

	// config writes always complete in the cycle they are offered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_DIM_MAX;
			src_height_q <= SRC_DIM_MAX;
			dst_width_q  <= DST_DIM_RESET;
			dst_height_q <= DST_DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_DIM_BITS-1:0];
				CFG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_DIM_BITS-1:0];
				CFG_DST_WIDTH:  dst_width_q  <= cfg_data;
				CFG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// source sizes of zero act as one, sizes above 64 act as 64
	always_comb begin
		cfg.src_w = clamp_src_dim(src_width_q);
		cfg.src_h = clamp_src_dim(src_height_q);
		cfg.dst_w = dst_width_q;
		cfg.dst_h = dst_height_q;
	end

	// front: accepts words, advances the load pointer, flags bad coordinates
	nnis_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.pixel_in  (pixel_in),
		.dst_x     (dst_x),
		.dst_y     (dst_y),
		.cfg       (cfg),
		.full      (full),
		.push      (push),
		.push_entry(push_entry)
	);

	// queue between the two parts
	nnis_fifo #(
		.WIDTH(ENTRY_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_entry),
		.pop      (pop),
		.pop_data (pop_bits),
		.full     (full),
		.empty    (empty)
	);

	assign pop_entry = queue_entry_t'(pop_bits);

	// back: divides, reduces the index, touches the store, drives the result
	nnis_back #(
		.MAX_PIXELS(MAX_PIXELS),
		.PIXEL_BITS(PIXEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.empty      (empty),
		.entry      (pop_entry),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.pixel_out  (pixel_out),
		.coord_error(coord_error)
	);

endmodule

// File: hw/rtl/nnis_ram.sv
module nnis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic             rd_en,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wr_data,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: hw/rtl/nnis_fifo.sv
module nnis_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW:0]      wr_ptr_q;
	logic [AW:0]      rd_ptr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q[AW-1:0]] <= push_data;
		end
	end

	assign pop_data = slot_q[rd_ptr_q[AW-1:0]];
	assign empty    = (wr_ptr_q == rd_ptr_q);
	assign full     = (wr_ptr_q[AW] != rd_ptr_q[AW]) &&
	                  (wr_ptr_q[AW-1:0] == rd_ptr_q[AW-1:0]);

endmodule

// File: hw/rtl/nnis_front.sv
module nnis_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                cmd,
	input  logic [nnis_pkg::WORD_BITS-1:0]      pixel_in,
	input  logic [nnis_pkg::COORD_BITS-1:0]     dst_x,
	input  logic [nnis_pkg::COORD_BITS-1:0]     dst_y,
	input  nnis_pkg::cfg_t                      cfg,
	input  logic                                full,
	output logic                                push,
	output nnis_pkg::queue_entry_t              push_entry
);

	import nnis_pkg::*;

	logic [INDEX_BITS-1:0] ptr_q;
	logic [AREA_BITS-1:0]  area;
	logic [AREA_BITS-1:0]  ptr_next;
	logic [NUM_BITS-1:0]   num_x;
	logic [NUM_BITS-1:0]   num_y;
	logic                  out_of_range;

	assign in_stall = full;
	assign push     = in_valid && !full;

	assign area     = cfg.src_w * cfg.src_h;
	assign ptr_next = {1'b0, ptr_q} + 1'b1;

	assign num_x = dst_x * cfg.src_w;
	assign num_y = dst_y * cfg.src_h;
	assign out_of_range = ({1'b0, dst_x} >= cfg.dst_w) || ({1'b0, dst_y} >= cfg.dst_h);

	always_comb begin
		push_entry.pixel = pixel_in;
		push_entry.num_x = num_x;
		push_entry.num_y = num_y;
		push_entry.ptr   = ptr_q;
		if (cmd == CMD_LOAD) begin
			push_entry.kind = KIND_LOAD;
		end else if (out_of_range) begin
			push_entry.kind = KIND_ERROR;
		end else begin
			push_entry.kind = KIND_FETCH;
		end
	end

	// write pointer wraps at the source area, also when the area shrank below it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (push && cmd == CMD_LOAD) begin
			if (ptr_next >= area) begin
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_next[INDEX_BITS-1:0];
			end
		end
	end

endmodule

// File: hw/rtl/nnis_back.sv
module nnis_back #(
	parameter int MAX_PIXELS = 4096,
	parameter int PIXEL_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nnis_pkg::cfg_t                  cfg,
	input  logic                            empty,
	input  nnis_pkg::queue_entry_t          entry,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [nnis_pkg::WORD_BITS-1:0]  pixel_out,
	output logic                            coord_error
);

	import nnis_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'((1 << RECIP_SHIFT) / MAX_PIXELS);
	localparam logic [DEPTH_BITS-1:0] MODULUS = DEPTH_BITS'(MAX_PIXELS);
	localparam int PROD_BITS = INDEX_BITS + RECIP_BITS;
	localparam int QM_BITS   = INDEX_BITS + DEPTH_BITS;

	back_state_t state_q;
	back_state_t state_d;

	item_kind_t            kind_q;
	logic [WORD_BITS-1:0]  pix_q;
	logic [NUM_BITS-1:0]   rem_x_q;
	logic [NUM_BITS-1:0]   rem_y_q;
	logic [NUM_BITS-1:0]   div_x_q;
	logic [NUM_BITS-1:0]   div_y_q;
	logic [QUOT_BITS-1:0]  quot_x_q;
	logic [QUOT_BITS-1:0]  quot_y_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [INDEX_BITS-1:0] val_q;
	logic [INDEX_BITS-1:0] qest_q;
	logic [INDEX_BITS-1:0] rem_q;
	logic [WORD_BITS-1:0]  res_pixel_q;
	logic                  res_err_q;
	logic                  out_valid_q;
	logic [WORD_BITS-1:0]  pixel_out_q;
	logic                  coord_error_q;

	logic                  ge_x;
	logic                  ge_y;
	logic [AREA_BITS-1:0]  idx_sum;
	logic [PROD_BITS-1:0]  prod;
	logic [QM_BITS-1:0]    qm;
	logic [QM_BITS-1:0]    diff;
	logic [INDEX_BITS-1:0] fix_idx;
	logic                  mem_we;
	logic                  mem_re;
	logic                  slot_free;
	logic                  out_load;
	logic [PIXEL_BITS-1:0] rd_data;

	assign ge_x    = rem_x_q >= div_x_q;
	assign ge_y    = rem_y_q >= div_y_q;
	assign idx_sum = quot_y_q * cfg.src_w + quot_x_q;
	assign prod    = val_q * RECIP;
	assign qm      = qest_q * MODULUS;
	assign diff    = {{DEPTH_BITS{1'b0}}, val_q} - qm;
	assign fix_idx = ({{(DEPTH_BITS-INDEX_BITS){1'b0}}, rem_q} >= MODULUS) ?
	                 (rem_q - MODULUS[INDEX_BITS-1:0]) : rem_q;

	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop = 1'b1;
					case (entry.kind)
						KIND_LOAD:  state_d = BK_MOD_MUL;
						KIND_FETCH: state_d = BK_DIV;
						default:    state_d = BK_DONE;
					endcase
				end
			end
			BK_DIV: begin
				if (step_q == LAST_STEP) begin
					state_d = BK_INDEX;
				end
			end
			BK_INDEX:   state_d = BK_MOD_MUL;
			BK_MOD_MUL: state_d = BK_MOD_SUB;
			BK_MOD_SUB: state_d = BK_MOD_FIX;
			BK_MOD_FIX: begin
				if (kind_q == KIND_LOAD) begin
					mem_we  = 1'b1;
					state_d = BK_IDLE;
				end else begin
					mem_re  = 1'b1;
					state_d = BK_READ;
				end
			end
			BK_READ: state_d = BK_DONE;
			BK_DONE: begin
				if (slot_free) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// datapath, walked by the sequencer above
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				kind_q    <= entry.kind;
				pix_q     <= entry.pixel;
				val_q     <= entry.ptr;
				rem_x_q   <= entry.num_x;
				rem_y_q   <= entry.num_y;
				div_x_q   <= {cfg.dst_w, {(QUOT_BITS-1){1'b0}}};
				div_y_q   <= {cfg.dst_h, {(QUOT_BITS-1){1'b0}}};
				step_q    <= '0;
				res_pixel_q <= '0;
				res_err_q   <= 1'b1;
			end
			BK_DIV: begin
				// restoring division, one quotient bit per axis per cycle
				if (ge_x) begin
					rem_x_q <= rem_x_q - div_x_q;
				end
				if (ge_y) begin
					rem_y_q <= rem_y_q - div_y_q;
				end
				quot_x_q <= {quot_x_q[QUOT_BITS-2:0], ge_x};
				quot_y_q <= {quot_y_q[QUOT_BITS-2:0], ge_y};
				div_x_q  <= div_x_q >> 1;
				div_y_q  <= div_y_q >> 1;
				step_q   <= step_q + 1'b1;
			end
			BK_INDEX: begin
				val_q <= idx_sum[INDEX_BITS-1:0];
			end
			BK_MOD_MUL: begin
				// quotient estimate, at most one too small
				qest_q <= prod[RECIP_SHIFT +: INDEX_BITS];
			end
			BK_MOD_SUB: begin
				rem_q <= diff[INDEX_BITS-1:0];
			end
			BK_READ: begin
				res_pixel_q <= WORD_BITS'(rd_data);
				res_err_q   <= 1'b0;
			end
			default: begin
			end
		endcase
	end

	nnis_ram #(
		.WIDTH(PIXEL_BITS),
		.DEPTH(MAX_PIXELS)
	) u_store (
		.clk    (clk),
		.wr_en  (mem_we),
		.rd_en  (mem_re),
		.addr   (AW'(fix_idx)),
		.wr_data(PIXEL_BITS'(pix_q)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_out_q   <= res_pixel_q;
			coord_error_q <= res_err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_out   = pixel_out_q;
	assign coord_error = coord_error_q;

endmodule

// File: hw/rtl/nnis_checker.sv
module nnis_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            cmd,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [nnis_pkg::WORD_BITS-1:0]  pixel_out,
	input logic                            coord_error
);

	import nnis_pkg::*;

	logic [3:0] pending_q;
	logic       fetch_in;
	logic       word_out;

	assign fetch_in = in_valid && !in_stall && cmd == CMD_FETCH;
	assign word_out = out_valid && !out_stall;

	// fetches taken but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {3'b0, fetch_in} - {3'b0, word_out};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(pixel_out) && $stable(coord_error))
		else $error("stalled result changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && coord_error |-> pixel_out == '0)
		else $error("error result carries a pixel");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a pending fetch");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_checker (.*);
